/* rtl/core/cllm_pkg.sv */
// ----------------------------------------------------------------------------
// cllm_pkg: shared types and constants for the circular list manager
// Operation codes, status codes, request/result structs and sequencer states.
// ----------------------------------------------------------------------------
package cllm_pkg;

  localparam int NODE_COUNT = 64;
  localparam int LIST_COUNT = 4;
  localparam int NW = $clog2(NODE_COUNT);
  localparam int LW = 2;

  typedef enum logic [2:0] {
    OP_INIT   = 3'd0,
    OP_APP_T  = 3'd1,
    OP_APP_H  = 3'd2,
    OP_REM    = 3'd3,
    OP_CREM   = 3'd4,
    OP_POP_H  = 3'd5,
    OP_POP_T  = 3'd6,
    OP_MERGE  = 3'd7
  } op_t;

  typedef enum logic [1:0] {
    ST_OK       = 2'd0,
    ST_EMPTY    = 2'd1,
    ST_NOTFOUND = 2'd2,
    ST_RANGE    = 2'd3
  } status_t;

  typedef struct packed {
    logic [2:0] op;
    logic [1:0] list_id;
    logic [1:0] target_list;
    logic [5:0] node;
    logic [6:0] count;
  } req_t;

  typedef struct packed {
    logic [5:0] out_node;
    logic       node_valid;
    logic [1:0] status;
  } res_t;

  typedef enum logic [3:0] {
    S_IDLE,
    S_DEC,
    S_INIT,
    S_RD1,
    S_RD2,
    S_WR1,
    S_WR2,
    S_SRCH,
    S_DONE
  } state_t;

endpackage

/* rtl/core/circular_linked_list_manager.sv */
// ----------------------------------------------------------------------------
// circular_linked_list_manager
// Pool of linked nodes with several circular doubly linked lists.
// ----------------------------------------------------------------------------
// channel  ports                    direction  handshake
// request  start, busy, in_req      in         start && !busy
// result   out_valid, out_res       out        strobe, one cycle
//
// busy is high from acceptance through the result strobe. Init writes the
// link memories one entry a cycle; checked remove reads each node visited and
// then compares it. After each result the manager returns to idle, where the
// next request is taken. Reset clears linked marks, heads and list flags at
// once; the link memories are not cleared. The receiver cannot stall.
module circular_linked_list_manager import cllm_pkg::*; (
  input  logic clk,
  input  logic rst_n,
  input  logic start,
  output logic busy,
  input  req_t in_req,
  output logic out_valid,
  output res_t out_res
);

  logic [NW-1:0] next_mem [NODE_COUNT];
  logic [NW-1:0] prev_mem [NODE_COUNT];
  logic [NODE_COUNT-1:0] linked_r, linked_nxt;
  logic [NW-1:0] head_r [LIST_COUNT];
  logic [NW-1:0] head_nxt [LIST_COUNT];
  logic [LIST_COUNT-1:0] ne_r, ne_nxt;

  state_t state_r, state_nxt;
  req_t req_r;
  res_t res_r, res_nxt;
  logic [NW-1:0] a_r, a_nxt, b_r, b_nxt, c_r, c_nxt, d_r, d_nxt;
  logic [NW:0] k_r, k_nxt;

  // memory port: one read address, one write address per memory
  logic [NW-1:0] raddr;
  logic [NW-1:0] rn_q, rp_q;
  logic          wn_en, wp_en;
  logic [NW-1:0] wn_a, wn_d, wp_a, wp_d;

  always_ff @(posedge clk) begin
    rn_q <= next_mem[raddr];
    rp_q <= prev_mem[raddr];
    if (wn_en) next_mem[wn_a] <= wn_d;
    if (wp_en) prev_mem[wp_a] <= wp_d;
  end

  logic [LW-1:0] l, t;
  logic [NW-1:0] n;
  logic [NW+1:0] sum;
  assign l = req_r.list_id;
  assign t = req_r.target_list;
  assign n = req_r.node;
  assign sum = {2'b00, n} + {1'b0, req_r.count};

  // next state
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      S_IDLE: if (start) state_nxt = S_DEC;
      S_DEC: begin
        state_nxt = S_DONE;
        unique case (op_t'(req_r.op))
          OP_INIT:
            if (req_r.count != 0 && !(req_r.count > 7'(NODE_COUNT) - 7'(n)))
              state_nxt = S_INIT;
          OP_APP_T, OP_APP_H: if (ne_r[l]) state_nxt = S_RD1; else state_nxt = S_WR1;
          OP_REM: if (linked_r[n]) state_nxt = S_RD1;
          OP_CREM: if (ne_r[l]) state_nxt = S_SRCH;
          OP_POP_H, OP_POP_T: if (ne_r[l]) state_nxt = S_RD1;
          OP_MERGE: if (t != l && ne_r[l] && ne_r[t]) state_nxt = S_RD1;
          default: state_nxt = S_DONE;
        endcase
      end
      S_INIT: if (k_r == req_r.count - 7'd1) state_nxt = S_DONE;
      S_RD1: state_nxt = S_RD2;
      S_RD2: begin
        // pop tail reads again at the tail node before unlinking
        if (op_t'(req_r.op) == OP_MERGE) state_nxt = S_SRCH;
        else if (op_t'(req_r.op) == OP_POP_T && !k_r[0]) state_nxt = S_RD1;
        else state_nxt = S_WR1;
      end
      S_WR1: begin
        // a node appended to an empty list needs no second write
        if ((op_t'(req_r.op) == OP_APP_T || op_t'(req_r.op) == OP_APP_H) && !ne_r[l])
          state_nxt = S_DONE;
        else state_nxt = S_WR2;
      end
      S_WR2: state_nxt = S_DONE;
      S_SRCH: state_nxt = S_SRCH;
      S_DONE: state_nxt = S_IDLE;
      default: state_nxt = S_IDLE;
    endcase
    // search and merge second read share S_SRCH
    if (state_r == S_SRCH) begin
      if (op_t'(req_r.op) == OP_MERGE) state_nxt = S_WR1;
      else if (k_r[0] && (c_r == n)) state_nxt = S_RD1;
      else if (k_r[0] && (rn_q == a_r)) state_nxt = S_DONE;
      else if (k_r[0] && k_r[NW:1] == NW'(NODE_COUNT - 1)) state_nxt = S_DONE;
    end
  end

  // datapath and outputs
  always_comb begin
    linked_nxt = linked_r;
    head_nxt = head_r;
    ne_nxt = ne_r;
    res_nxt = res_r;
    a_nxt = a_r; b_nxt = b_r; c_nxt = c_r; d_nxt = d_r; k_nxt = k_r;
    raddr = a_r;
    wn_en = 1'b0; wp_en = 1'b0;
    wn_a = '0; wn_d = '0; wp_a = '0; wp_d = '0;
    unique case (state_r)
      S_IDLE: ;
      S_DEC: begin
        res_nxt = '0;
        k_nxt = '0;
        unique case (op_t'(req_r.op))
          OP_INIT: begin
            if (req_r.count == 0) begin
              ne_nxt[l] = 1'b0; head_nxt[l] = '0;
            end else if (sum > (NW+2)'(NODE_COUNT)) res_nxt.status = ST_RANGE;
            a_nxt = n;
          end
          OP_APP_T, OP_APP_H: a_nxt = head_r[l];
          OP_REM: begin
            if (!linked_r[n]) res_nxt.status = ST_NOTFOUND;
            else if (!ne_r[l]) res_nxt.status = ST_EMPTY;
            a_nxt = n;
          end
          OP_CREM: begin
            if (!ne_r[l]) res_nxt.status = ST_EMPTY;
            else res_nxt.status = ST_NOTFOUND;
            a_nxt = head_r[l]; c_nxt = head_r[l];
          end
          OP_POP_H, OP_POP_T: begin
            if (!ne_r[l]) res_nxt.status = ST_EMPTY;
            a_nxt = head_r[l];
          end
          OP_MERGE: begin
            if (t != l) begin
              if (!ne_r[l]) res_nxt.status = ST_EMPTY;
              else if (!ne_r[t]) begin
                head_nxt[t] = head_r[l]; ne_nxt[t] = 1'b1;
                ne_nxt[l] = 1'b0; head_nxt[l] = '0;
              end
            end
            a_nxt = head_r[t]; b_nxt = head_r[l];
          end
          default: ;
        endcase
      end
      S_INIT: begin
        // link one node of the new circle per cycle
        c_nxt = NW'(k_r);
        wn_en = 1'b1; wp_en = 1'b1;
        wn_a = n + NW'(k_r); wp_a = wn_a;
        wn_d = (k_r == req_r.count - 7'd1) ? n : wn_a + NW'(1);
        wp_d = (k_r == 0) ? NW'(sum - 1'b1) : wn_a - NW'(1);
        linked_nxt[wn_a] = 1'b1;
        k_nxt = k_r + 1'b1;
        if (k_r == req_r.count - 7'd1) begin
          head_nxt[l] = n; ne_nxt[l] = 1'b1;
        end
      end
      S_RD1: raddr = a_r;
      S_RD2: begin
        // a_r's links arrive; pop tail redirects to the tail node once
        c_nxt = rp_q; d_nxt = rn_q;
        if (op_t'(req_r.op) == OP_POP_T && !k_r[0]) begin
          a_nxt = rp_q; k_nxt = k_r + 1'b1;
        end
        if (op_t'(req_r.op) == OP_MERGE) raddr = b_r;
      end
      S_SRCH: begin
        if (op_t'(req_r.op) == OP_MERGE) begin
          b_nxt = b_r; d_nxt = rp_q; // d = source tail, c = target tail
        end else begin
          // even phase reads c, odd phase compares and steps
          raddr = c_r;
          k_nxt = k_r + 1'b1;
          if (k_r[0]) begin
            if (c_r == n) begin
              res_nxt.status = ST_OK; a_nxt = n;
            end
            c_nxt = rn_q;
          end
        end
      end
      S_WR1: begin
        unique case (op_t'(req_r.op))
          OP_APP_T, OP_APP_H: begin
            if (!ne_r[l]) begin
              wn_en = 1'b1; wp_en = 1'b1;
              wn_a = n; wn_d = n; wp_a = n; wp_d = n;
              head_nxt[l] = n; ne_nxt[l] = 1'b1;
            end else begin
              // a = head, c = tail
              wn_en = 1'b1; wp_en = 1'b1;
              wn_a = n; wn_d = a_r; wp_a = n; wp_d = c_r;
            end
            linked_nxt[n] = 1'b1;
          end
          OP_MERGE: begin
            wp_en = 1'b1; wn_en = 1'b1;
            wp_a = a_r; wp_d = d_r; wn_a = d_r; wn_d = a_r;
          end
          default: begin
            // unlink a: c = prev, d = next
            if (ne_r[l] && d_r != a_r) begin
              wp_en = 1'b1; wp_a = d_r; wp_d = c_r;
              wn_en = 1'b1; wn_a = c_r; wn_d = d_r;
            end
          end
        endcase
      end
      S_WR2: begin
        unique case (op_t'(req_r.op))
          OP_APP_T, OP_APP_H: begin
            if (ne_r[l]) begin
              wp_en = 1'b1; wp_a = a_r; wp_d = n;
              wn_en = 1'b1; wn_a = c_r; wn_d = n;
            end
            if (op_t'(req_r.op) == OP_APP_H) head_nxt[l] = n;
          end
          OP_MERGE: begin
            wp_en = 1'b1; wp_a = b_r; wp_d = c_r;
            wn_en = 1'b1; wn_a = c_r; wn_d = b_r;
            ne_nxt[l] = 1'b0; head_nxt[l] = '0;
          end
          default: begin
            if (ne_r[l]) begin
              if (d_r == a_r) begin
                ne_nxt[l] = 1'b0; head_nxt[l] = '0;
              end else if (head_r[l] == a_r) head_nxt[l] = d_r;
            end
            linked_nxt[a_r] = 1'b0;
            if (op_t'(req_r.op) == OP_POP_H || op_t'(req_r.op) == OP_POP_T) begin
              res_nxt.out_node = a_r; res_nxt.node_valid = 1'b1;
            end
          end
        endcase
      end
      S_DONE: ;
      default: ;
    endcase
  end

  assign busy = (state_r != S_IDLE);
  assign out_valid = (state_r == S_DONE);
  assign out_res = res_r;

  // hold registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
      linked_r <= '0;
      ne_r <= '0;
      for (int i = 0; i < LIST_COUNT; i++) head_r[i] <= '0;
    end else begin
      state_r <= state_nxt;
      linked_r <= linked_nxt;
      ne_r <= ne_nxt;
      head_r <= head_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (start && !busy) req_r <= in_req;
    res_r <= res_nxt;
    a_r <= a_nxt; b_r <= b_nxt; c_r <= c_nxt; d_r <= d_nxt; k_r <= k_nxt;
  end

endmodule

/* tb/circular_linked_list_manager_checker.sv */
// ----------------------------------------------------------------------------
// circular_linked_list_manager_checker
// Watches the request and result channels, keeps its own copy of the node
// pool and the list heads, predicts each result and compares it field by field.
// ----------------------------------------------------------------------------
module circular_linked_list_manager_checker import cllm_pkg::*; (
  input  logic clk,
  input  logic rst_n,
  input  logic start,
  input  logic busy,
  input  req_t in_req,
  input  logic out_valid,
  input  res_t out_res,
  output int   fail_count,
  output int   pending
);
  timeunit 1ns;
  timeprecision 1ps;

  logic [5:0] nxt_q [NODE_COUNT];
  logic [5:0] prv_q [NODE_COUNT];
  bit         linked_q [NODE_COUNT];
  logic [5:0] head_q [LIST_COUNT];
  bit         nonempty_q [LIST_COUNT];
  res_t       expected_results [$];

  // Take node n out of its circle on behalf of list l
  function automatic void unlink_node(int l, logic [5:0] n);
    logic [5:0] p, x;
    p = prv_q[n];
    x = nxt_q[n];
    if (nonempty_q[l]) begin
      if (x == n) begin
        nonempty_q[l] = 0;
        head_q[l] = '0;
      end else begin
        prv_q[x] = p;
        nxt_q[p] = x;
        if (head_q[l] == n) head_q[l] = x;
      end
    end
    linked_q[n] = 0;
  endfunction

  // Insert node n before the head of list l
  function automatic void link_tail(int l, logic [5:0] n);
    logic [5:0] h, t;
    if (!nonempty_q[l]) begin
      head_q[l] = n;
      nonempty_q[l] = 1;
      nxt_q[n] = n;
      prv_q[n] = n;
    end else begin
      h = head_q[l];
      t = prv_q[h];
      nxt_q[n] = h;
      prv_q[n] = t;
      prv_q[h] = n;
      nxt_q[t] = n;
    end
    linked_q[n] = 1;
  endfunction

  // Apply one request to the pool and return the result it produces
  function automatic res_t apply_request(req_t r);
    res_t       res;
    int         l, t, k;
    logic [5:0] h, cur, th, fh, tt, ft, v;
    bit         found;
    res = '0;
    l = r.list_id;
    t = r.target_list;
    case (op_t'(r.op))
      OP_INIT: begin
        if (r.count == 0) begin
          nonempty_q[l] = 0;
          head_q[l] = '0;
        end else if (int'(r.node) + int'(r.count) > NODE_COUNT) begin
          res.status = ST_RANGE;
        end else begin
          for (int i = r.node; i < int'(r.node) + int'(r.count); i++) begin
            prv_q[i] = (i == r.node) ? 6'(r.node + r.count - 1) : 6'(i - 1);
            nxt_q[i] = (i == r.node + r.count - 1) ? r.node : 6'(i + 1);
            linked_q[i] = 1;
          end
          head_q[l] = r.node;
          nonempty_q[l] = 1;
        end
      end
      OP_APP_T, OP_APP_H: begin
        link_tail(l, r.node);
        if (op_t'(r.op) == OP_APP_H) head_q[l] = r.node;
      end
      OP_REM: begin
        if (!linked_q[r.node]) begin
          res.status = ST_NOTFOUND;
        end else begin
          if (!nonempty_q[l]) res.status = ST_EMPTY;
          unlink_node(l, r.node);
        end
      end
      OP_CREM: begin
        if (!nonempty_q[l]) begin
          res.status = ST_EMPTY;
        end else begin
          h = head_q[l];
          cur = h;
          found = 0;
          for (k = 0; k < NODE_COUNT && !found; k++) begin
            if (cur == r.node) found = 1;
            cur = nxt_q[cur];
            if (cur == h) break;
          end
          if (found) unlink_node(l, r.node);
          else res.status = ST_NOTFOUND;
        end
      end
      OP_POP_H, OP_POP_T: begin
        if (!nonempty_q[l]) begin
          res.status = ST_EMPTY;
        end else begin
          h = head_q[l];
          v = (op_t'(r.op) == OP_POP_H) ? h : prv_q[h];
          unlink_node(l, v);
          res.out_node = v;
          res.node_valid = 1'b1;
        end
      end
      default: begin
        if (t == l) begin
          res.status = ST_OK;
        end else if (!nonempty_q[l]) begin
          res.status = ST_EMPTY;
        end else if (!nonempty_q[t]) begin
          head_q[t] = head_q[l];
          nonempty_q[t] = 1;
          nonempty_q[l] = 0;
          head_q[l] = '0;
        end else begin
          th = head_q[t];
          fh = head_q[l];
          tt = prv_q[th];
          ft = prv_q[fh];
          prv_q[th] = ft;
          prv_q[fh] = tt;
          nxt_q[ft] = th;
          nxt_q[tt] = fh;
          nonempty_q[l] = 0;
          head_q[l] = '0;
        end
      end
    endcase
    return res;
  endfunction

  // Compare results first, then record the new request
  always @(posedge clk) begin
    res_t exp_res;
    if (!rst_n) begin
      for (int i = 0; i < NODE_COUNT; i++) begin
        nxt_q[i] = '0;
        prv_q[i] = '0;
        linked_q[i] = 0;
      end
      for (int i = 0; i < LIST_COUNT; i++) begin
        head_q[i] = '0;
        nonempty_q[i] = 0;
      end
      expected_results.delete();
      fail_count = 0;
    end else begin
      if (out_valid) begin
        if (expected_results.size() == 0) begin
          fail_count++;
          if (fail_count <= 10)
            $display("unexpected result: node=%0d valid=%0d status=%0d",
                     out_res.out_node, out_res.node_valid, out_res.status);
        end else begin
          exp_res = expected_results.pop_front();
          if (out_res.out_node !== exp_res.out_node ||
              out_res.node_valid !== exp_res.node_valid ||
              out_res.status !== exp_res.status) begin
            fail_count++;
            if (fail_count <= 10)
              $display("mismatch: exp node=%0d valid=%0d status=%0d, got node=%0d valid=%0d status=%0d",
                       exp_res.out_node, exp_res.node_valid, exp_res.status,
                       out_res.out_node, out_res.node_valid, out_res.status);
          end
        end
      end
      if (start && !busy)
        expected_results.push_back(apply_request(in_req));
    end
    pending = expected_results.size();
  end
endmodule

/* tb/tb.sv */
// ----------------------------------------------------------------------------
// tb: circular linked list manager testbench
// Drives directed and random list requests under varying sender gaps and
// reports the verdict from the checker's failure count.
// ----------------------------------------------------------------------------
module tb;
  import cllm_pkg::*;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int CYCLE_LIMIT = 2000000;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic start = 1'b0;
  req_t in_req = '0;
  logic busy, out_valid;
  res_t out_res;
  int   fail_count, pending;
  int   cycles = 0;
  int   idle_pct;

  always #6 clk = ~clk;

  circular_linked_list_manager u_dut (
    .clk(clk), .rst_n(rst_n), .start(start), .busy(busy),
    .in_req(in_req), .out_valid(out_valid), .out_res(out_res)
  );

  circular_linked_list_manager_checker u_chk (
    .clk(clk), .rst_n(rst_n), .start(start), .busy(busy), .in_req(in_req),
    .out_valid(out_valid), .out_res(out_res),
    .fail_count(fail_count), .pending(pending)
  );

  // Abort a hung run
  always @(posedge clk) begin
    cycles++;
    if (cycles >= CYCLE_LIMIT) begin
      $display("FAIL circular_linked_list_manager");
      $finish;
    end
  end

  // Present one request and hold it until accepted, then maybe idle
  task automatic send_request(op_t op, int lid, int tgt, int nd, int cnt);
    start <= 1'b1;
    in_req <= '{op: op, list_id: 2'(lid), target_list: 2'(tgt),
                node: 6'(nd), count: 7'(cnt)};
    do @(posedge clk); while (busy);
    @(negedge clk);
    if ($urandom_range(99) < idle_pct) begin
      start <= 1'b0;
      repeat ($urandom_range(1, ($urandom_range(9) == 0) ? 20 : 3)) @(negedge clk);
    end
  endtask

  // Build a random request, mostly on a small set of nodes so lists collide
  task automatic send_random();
    op_t op;
    int  nd, cnt;
    op = op_t'($urandom_range(7));
    nd = ($urandom_range(3) == 0) ? $urandom_range(63) : $urandom_range(15);
    case ($urandom_range(9))
      0:       cnt = 64;
      1:       cnt = $urandom_range(64);
      default: cnt = $urandom_range(6);
    endcase
    if (op == OP_INIT && $urandom_range(3) != 0 && nd + cnt > NODE_COUNT)
      nd = NODE_COUNT - cnt;
    send_request(op, $urandom_range(3), $urandom_range(3), nd, cnt);
  endtask

  initial begin
    idle_pct = 0;
    repeat (11) @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    // Directed: every operation and each corner case
    send_request(OP_INIT, 0, 0, 0, 8);
    send_request(OP_INIT, 1, 0, 60, 5);
    send_request(OP_INIT, 1, 0, 56, 8);
    send_request(OP_INIT, 2, 0, 63, 0);
    send_request(OP_APP_T, 2, 0, 20, 0);
    send_request(OP_APP_H, 2, 0, 21, 0);
    send_request(OP_APP_T, 2, 0, 22, 0);
    send_request(OP_POP_H, 2, 0, 0, 0);
    send_request(OP_POP_T, 2, 0, 0, 0);
    send_request(OP_POP_T, 2, 0, 0, 0);
    send_request(OP_POP_H, 2, 3, 63, 127);
    send_request(OP_REM, 0, 0, 3, 0);
    send_request(OP_REM, 0, 0, 40, 0);
    send_request(OP_REM, 2, 0, 57, 0);
    send_request(OP_CREM, 0, 0, 5, 0);
    send_request(OP_CREM, 0, 0, 30, 0);
    send_request(OP_CREM, 3, 0, 1, 0);
    send_request(OP_APP_T, 0, 0, 58, 0);
    send_request(OP_MERGE, 1, 0, 0, 0);
    send_request(OP_MERGE, 0, 0, 0, 0);
    send_request(OP_MERGE, 3, 0, 0, 0);
    send_request(OP_MERGE, 0, 3, 0, 0);
    send_request(OP_INIT, 1, 0, 0, 64);
    send_request(OP_CREM, 1, 0, 63, 0);

    // Random: sweep sender idling phases
    for (int ph = 0; ph < 4; ph++) begin
      case (ph)
        0: idle_pct = 0;
        1: idle_pct = 77;
        2: idle_pct = 0;
        default: idle_pct = 14;
      endcase
      for (int i = 0; i < 450; i++) send_random();
      // Hold off until every result has come back
      start <= 1'b0;
      while (pending != 0) @(negedge clk);
    end
    start <= 1'b0;

    while (pending != 0) @(negedge clk);
    repeat (100) @(posedge clk);
    if (fail_count == 0) begin
      $display("PASS circular_linked_list_manager");
    end else begin
      $display("FAIL circular_linked_list_manager");
    end
    $finish;
  end
endmodule

/* circular_linked_list_manager.f */
rtl/core/cllm_pkg.sv
rtl/core/circular_linked_list_manager.sv
tb/circular_linked_list_manager_checker.sv
tb/tb.sv
